// ----- sv/pic_pkg.sv -----
// shared types, constants and lookup functions for the png image carver
`timescale 1ns / 1ps
package pic_pkg;

  localparam int unsigned DefBufferBytes = 65536;
  localparam int unsigned DefResultLimit = 64;
  localparam int unsigned SigLen         = 8;
  localparam int unsigned ChunkOverhead  = 12;
  localparam logic [31:0] TypeIhdr       = 32'd1229472850;
  localparam logic [31:0] TypeIend       = 32'd1229278788;

  typedef enum logic [3:0] {
    S_LOAD,
    S_SIG_START,
    S_SIG_RD,
    S_SIG_CMP,
    S_CH_START,
    S_CH_RD,
    S_CH_CAP,
    S_CH_CHK,
    S_FOUND,
    S_FINISH
  } pic_state_e;

  typedef struct packed {
    logic        found;
    logic [15:0] image_start;
    logic [16:0] image_length;
    logic        last_result;
    logic        truncated;
    logic        input_overflow;
  } pic_res_t;

  function automatic logic [7:0] sig_byte(input logic [2:0] k);
    logic [7:0] b;
    case (k)
      3'd0:    b = 8'h89;
      3'd1:    b = 8'h50;
      3'd2:    b = 8'h4e;
      3'd3:    b = 8'h47;
      3'd4:    b = 8'h0d;
      3'd5:    b = 8'h0a;
      3'd6:    b = 8'h1a;
      3'd7:    b = 8'h0a;
      default: b = 8'h00;
    endcase
    return b;
  endfunction

  function automatic logic type_known(input logic [31:0] t);
    logic k;
    case (t)
      32'd1229472850, 32'd1347179589, 32'd1229209940, 32'd1229278788,
      32'd1649100612, 32'd1665684045, 32'd1683179847, 32'd1700284774,
      32'd1732332865, 32'd1749635924, 32'd1766015824, 32'd1767135348,
      32'd1883789683, 32'd1933723988, 32'd1934642260, 32'd1934772034,
      32'd1934902610, 32'd1950701684, 32'd1950960965, 32'd1951551059,
      32'd2052348020: k = 1'b1;
      default:        k = 1'b0;
    endcase
    return k;
  endfunction

endpackage

// ----- sv/pic_ram.sv -----
// generic single write port ram with registered read
`timescale 1ns / 1ps
module pic_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

// ----- sv/pic_scan.sv -----
// load sequencer and byte-serial signature search and chunk walker
`timescale 1ns / 1ps
module pic_scan #(
  parameter int unsigned BUFFER_BYTES = pic_pkg::DefBufferBytes,
  parameter int unsigned RESULT_LIMIT = pic_pkg::DefResultLimit
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic [7:0]                      data_byte_i,
  input  logic                            last_byte_i,
  output logic                            ram_we_o,
  output logic [$clog2(BUFFER_BYTES)-1:0] ram_waddr_o,
  output logic [7:0]                      ram_wdata_o,
  output logic [$clog2(BUFFER_BYTES)-1:0] ram_raddr_o,
  input  logic [7:0]                      ram_rdata_i,
  output logic                            res_valid_o,
  input  logic                            res_ready_i,
  output pic_pkg::pic_res_t               res_o
);
  import pic_pkg::*;

  localparam int unsigned AW = $clog2(BUFFER_BYTES);
  localparam int unsigned PW = AW + 2;
  localparam int unsigned EW = (PW > 32) ? PW + 2 : 34;

  pic_state_e state_q, state_d;
  logic [AW:0]   cnt_q, cnt_d;
  logic          ovf_q, ovf_d;
  logic [PW-1:0] pos_q, pos_d;
  logic [PW-1:0] cand_q, cand_d;
  logic [PW-1:0] idx_q, idx_d;
  logic [2:0]    k_q, k_d;
  logic          first_q, first_d;
  logic [63:0]   hdr_q, hdr_d;
  logic          pend_q, pend_d;
  logic [15:0]   pstart_q, pstart_d;
  logic [16:0]   plen_q, plen_d;
  logic [6:0]    n_q, n_d;
  logic          trunc_q, trunc_d;

  logic [PW-1:0] cnt_ext;
  logic [EW-1:0] chunk_end;
  logic [31:0]   ctype;
  logic          full;

  assign cnt_ext   = PW'(cnt_q);
  assign ctype     = hdr_q[31:0];
  assign chunk_end = EW'(idx_q) + EW'(ChunkOverhead) + EW'(hdr_q[63:32]);
  assign full      = (cnt_q == (AW+1)'(BUFFER_BYTES));

  assign ram_wdata_o = data_byte_i;
  assign ram_waddr_o = cnt_q[AW-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_LOAD;
      cnt_q   <= '0;
      ovf_q   <= 1'b0;
      pos_q   <= '0;
      cand_q  <= '0;
      idx_q   <= '0;
      k_q     <= '0;
      first_q <= 1'b1;
      pend_q  <= 1'b0;
      n_q     <= '0;
      trunc_q <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      ovf_q   <= ovf_d;
      pos_q   <= pos_d;
      cand_q  <= cand_d;
      idx_q   <= idx_d;
      k_q     <= k_d;
      first_q <= first_d;
      pend_q  <= pend_d;
      n_q     <= n_d;
      trunc_q <= trunc_d;
    end
  end

  always_ff @(posedge clk_i) begin
    hdr_q    <= hdr_d;
    pstart_q <= pstart_d;
    plen_q   <= plen_d;
  end

  always_comb begin
    state_d  = state_q;
    cnt_d    = cnt_q;
    ovf_d    = ovf_q;
    pos_d    = pos_q;
    cand_d   = cand_q;
    idx_d    = idx_q;
    k_d      = k_q;
    first_d  = first_q;
    hdr_d    = hdr_q;
    pend_d   = pend_q;
    pstart_d = pstart_q;
    plen_d   = plen_q;
    n_d      = n_q;
    trunc_d  = trunc_q;
    in_ready_o  = 1'b0;
    ram_we_o    = 1'b0;
    ram_raddr_o = pos_q[AW-1:0];
    res_valid_o = 1'b0;
    res_o.found          = pend_q;
    res_o.image_start    = pend_q ? pstart_q : 16'd0;
    res_o.image_length   = pend_q ? plen_q : 17'd0;
    res_o.last_result    = 1'b1;
    res_o.truncated      = trunc_q;
    res_o.input_overflow = ovf_q;

    case (state_q)
      S_LOAD: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          if (full) begin
            ovf_d = 1'b1;
          end else begin
            ram_we_o = 1'b1;
            cnt_d    = cnt_q + (AW+1)'(1);
          end
          if (last_byte_i) begin
            pos_d   = '0;
            pend_d  = 1'b0;
            n_d     = '0;
            trunc_d = 1'b0;
            state_d = S_SIG_START;
          end
        end
      end
      S_SIG_START: begin
        k_d = '0;
        if ((pos_q + PW'(SigLen)) > cnt_ext) begin
          state_d = S_FINISH;
        end else begin
          state_d = S_SIG_RD;
        end
      end
      S_SIG_RD: begin
        ram_raddr_o = AW'(pos_q + PW'(k_q));
        state_d     = S_SIG_CMP;
      end
      S_SIG_CMP: begin
        if (ram_rdata_i == sig_byte(k_q)) begin
          if (k_q == 3'd7) begin
            cand_d  = pos_q;
            idx_d   = pos_q + PW'(SigLen);
            first_d = 1'b1;
            state_d = S_CH_START;
          end else begin
            k_d     = k_q + 3'd1;
            state_d = S_SIG_RD;
          end
        end else begin
          pos_d   = pos_q + PW'(1);
          state_d = S_SIG_START;
        end
      end
      S_CH_START: begin
        k_d = '0;
        if ((idx_q + PW'(SigLen)) > cnt_ext) begin
          pos_d   = cand_q + PW'(SigLen);
          state_d = S_SIG_START;
        end else begin
          state_d = S_CH_RD;
        end
      end
      S_CH_RD: begin
        ram_raddr_o = AW'(idx_q + PW'(k_q));
        state_d     = S_CH_CAP;
      end
      S_CH_CAP: begin
        hdr_d = {hdr_q[55:0], ram_rdata_i};
        if (k_q == 3'd7) begin
          state_d = S_CH_CHK;
        end else begin
          k_d     = k_q + 3'd1;
          state_d = S_CH_RD;
        end
      end
      S_CH_CHK: begin
        if (!type_known(ctype) || (chunk_end > EW'(cnt_q)) ||
            (first_q && (ctype != TypeIhdr))) begin
          pos_d   = cand_q + PW'(SigLen);
          state_d = S_SIG_START;
        end else begin
          first_d = 1'b0;
          idx_d   = PW'(chunk_end);
          state_d = (ctype == TypeIend) ? S_FOUND : S_CH_START;
        end
      end
      S_FOUND: begin
        if (n_q == 7'(RESULT_LIMIT)) begin
          trunc_d = 1'b1;
          state_d = S_FINISH;
        end else begin
          res_valid_o       = pend_q;
          res_o.last_result = 1'b0;
          res_o.truncated   = 1'b0;
          if (!pend_q || res_ready_i) begin
            pend_d   = 1'b1;
            pstart_d = 16'(cand_q);
            plen_d   = 17'(idx_q - cand_q);
            n_d      = n_q + 7'd1;
            pos_d    = idx_q;
            state_d  = S_SIG_START;
          end
        end
      end
      S_FINISH: begin
        res_valid_o = 1'b1;
        if (res_ready_i) begin
          cnt_d   = '0;
          ovf_d   = 1'b0;
          first_d = 1'b1;
          state_d = S_LOAD;
        end
      end
      default: begin
        state_d = S_LOAD;
      end
    endcase
  end

endmodule

// ----- sv/png_image_carver.sv -----
// top level of the png image carver with byte store and result register
`timescale 1ns / 1ps
// Usage:
// Bytes arrive on the input channel (in_valid_i / in_ready_o), one byte per
// transaction, stored in order at one byte per cycle. A byte with
// last_byte_i set starts the scan; bytes beyond BUFFER_BYTES are dropped and
// reported through input_overflow_o. While the scan runs in_ready_o is low.
// The scan reads the store one byte at a time through the single read
// port: it compares the signature byte by byte at each buffer position,
// and after a full match reads each chunk header byte by byte and checks
// its type and length, so the search speed on plain data is set by the
// memory read port and the byte-serial compare.
// Results leave on the output channel (out_valid_o / out_ready_i) through a
// one-entry output register, one per image in buffer order, at most
// RESULT_LIMIT, the final one marked by last_result_o; with no image a
// single result with found_o low. A stalled receiver holds the scan at its
// next result; the block reopens for bytes once the final result has
// entered the output register. Reset empties the buffer and the output
// register; the store content is not cleared and needs no clearing pass.
module png_image_carver #(
  parameter int unsigned BUFFER_BYTES = pic_pkg::DefBufferBytes,
  parameter int unsigned RESULT_LIMIT = pic_pkg::DefResultLimit
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  data_byte_i,
  input  logic        last_byte_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        found_o,
  output logic [15:0] image_start_o,
  output logic [16:0] image_length_o,
  output logic        last_result_o,
  output logic        truncated_o,
  output logic        input_overflow_o
);
  import pic_pkg::*;

  localparam int unsigned AW = $clog2(BUFFER_BYTES);

  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [7:0]    ram_wdata;
  logic [AW-1:0] ram_raddr;
  logic [7:0]    ram_rdata;
  logic          res_valid;
  logic          res_ready;
  pic_res_t      res;
  logic          out_valid_q;
  pic_res_t      out_q;

  pic_ram #(
    .Width (8),
    .Depth (BUFFER_BYTES)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  pic_scan #(
    .BUFFER_BYTES (BUFFER_BYTES),
    .RESULT_LIMIT (RESULT_LIMIT)
  ) u_scan (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .data_byte_i (data_byte_i),
    .last_byte_i (last_byte_i),
    .ram_we_o    (ram_we),
    .ram_waddr_o (ram_waddr),
    .ram_wdata_o (ram_wdata),
    .ram_raddr_o (ram_raddr),
    .ram_rdata_i (ram_rdata),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_o       (res)
  );

  assign res_ready = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_ready) begin
      out_valid_q <= res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_ready && res_valid) begin
      out_q <= res;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign found_o          = out_q.found;
  assign image_start_o    = out_q.image_start;
  assign image_length_o   = out_q.image_length;
  assign last_result_o    = out_q.last_result;
  assign truncated_o      = out_q.truncated;
  assign input_overflow_o = out_q.input_overflow;

  a_none_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !found_o) |-> last_result_o)
    else $error("empty result not marked last");

  a_trunc_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && truncated_o) |-> (last_result_o && found_o))
    else $error("truncated flag on a non-final result");

  a_no_load_in_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid |-> !in_ready_o)
    else $error("input open while scan emits results");

endmodule
